// File: rtl/trd_pkg.sv
`timescale 1ns / 1ps
package trd_pkg;

  localparam int POS_W = 21;
  localparam int ANG_W = 14;
  localparam int FLAG_W = 6;
  localparam int DATA_BYTES = 15;
  localparam int STORE_BYTES = DATA_BYTES - 1;
  localparam logic [3:0] IDX_START = 4'd0;
  localparam logic [3:0] IDX_FIRST = 4'd1;
  localparam logic [3:0] IDX_LAST = 4'd15;

  typedef logic [6:0] dbyte_t;

  typedef struct packed {
    logic                        at_last;
    logic                        done;
    logic                        resync;
    logic [FLAG_W-1:0]           flags;
    logic [DATA_BYTES-1:0][6:0]  bytes;
  } frame_t;

endpackage

// File: rtl/trd_ifs.sv
`timescale 1ns / 1ps
interface trd_byte_if;
  logic       valid;
  logic       ready;
  logic [7:0] rx_byte;

  modport source (output valid, output rx_byte, input ready);
  modport sink (input valid, input rx_byte, output ready);
endinterface

interface trd_report_if;
  logic               valid;
  logic               ready;
  logic signed [20:0] pos_x;
  logic signed [20:0] pos_y;
  logic signed [20:0] pos_z;
  logic signed [13:0] pitch;
  logic signed [13:0] yaw;
  logic signed [13:0] roll;
  logic               fringe;
  logic               out_of_range;
  logic [3:0]         buttons;
  logic               changed;
  logic               resynced;

  modport source (
    output valid, output pos_x, output pos_y, output pos_z,
    output pitch, output yaw, output roll, output fringe,
    output out_of_range, output buttons, output changed, output resynced,
    input ready
  );
  modport sink (
    input valid, input pos_x, input pos_y, input pos_z,
    input pitch, input yaw, input roll, input fringe,
    input out_of_range, input buttons, input changed, input resynced,
    output ready
  );
endinterface

// File: rtl/trd_collect.sv
`timescale 1ns / 1ps
module trd_collect
  import trd_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  input  logic       accept,
  input  logic [7:0] rx_byte,
  output frame_t     frame
);

  logic [3:0]                  byte_index;
  logic [3:0]                  byte_index_next;
  logic [FLAG_W-1:0]           header_flags;
  logic                        resync_seen;
  logic [STORE_BYTES-1:0][6:0] store;

  // data bytes shift in, oldest at the top
  always_comb begin
    if (byte_index == IDX_LAST) begin
      byte_index_next = IDX_START;
    end else begin
      byte_index_next = byte_index + IDX_FIRST;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      byte_index   <= IDX_START;
      header_flags <= '0;
      resync_seen  <= 1'b0;
    end else if (accept) begin
      if (byte_index == IDX_START) begin
        if (!rx_byte[7]) begin
          resync_seen <= 1'b1;
        end else begin
          header_flags <= {rx_byte[6:5], rx_byte[3:0]};
          byte_index   <= IDX_FIRST;
        end
      end else begin
        byte_index <= byte_index_next;
        if (byte_index == IDX_LAST) begin
          resync_seen <= 1'b0;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept && byte_index != IDX_START) begin
      store <= {store[STORE_BYTES-2:0], rx_byte[6:0]};
    end
  end

  always_comb begin
    frame.at_last = (byte_index == IDX_LAST);
    frame.done    = accept && (byte_index == IDX_LAST);
    frame.resync  = resync_seen;
    frame.flags   = header_flags;
    frame.bytes   = {store, rx_byte[6:0]};
  end

endmodule

// File: rtl/tracker_report_deframer.sv
`timescale 1ns / 1ps
// tracker report deframer
// rx: one serial byte per request (valid/ready). a frame is a header byte
// with bit 7 set and 15 data bytes whose low 7 bits carry three signed
// 21-bit positions and three signed 14-bit angles. bytes without bit 7
// seen while waiting for a header are dropped and flagged as a resync.
// rpt: one report per frame (valid/ready) with positions, angles, header
// flags, a changed flag against the previous report and the resync flag.
// the report is registered and goes valid in the cycle after the last data byte is taken.
// throughput: one byte per cycle; rx.ready drops only when the last byte of
// a frame would arrive while the previous report is still stalled on rpt,
// so a receiver that keeps up never slows the byte stream.
// reset: waits for a header byte, no report pending, previous report taken
// as x = -1 and every other field zero.
// a stalled report holds its payload until rpt.ready is seen.
module tracker_report_deframer
  import trd_pkg::*;
(
  input  logic          clk,
  input  logic          rst,
  trd_byte_if.sink      rx,
  trd_report_if.source  rpt
);

  frame_t             frame;
  logic               accept;
  logic [POS_W-1:0]   cur_x, cur_y, cur_z;
  logic [ANG_W-1:0]   cur_pitch, cur_yaw, cur_roll;
  logic [POS_W-1:0]   last_x, last_y, last_z;
  logic [ANG_W-1:0]   last_pitch, last_yaw, last_roll;
  logic [FLAG_W-1:0]  last_flags;
  logic               diff;

  assign rx.ready = !(frame.at_last && rpt.valid && !rpt.ready);
  assign accept = rx.valid && rx.ready;

  trd_collect u_collect (
    .clk     (clk),
    .rst     (rst),
    .accept  (accept),
    .rx_byte (rx.rx_byte),
    .frame   (frame)
  );

  always_comb begin
    cur_x     = {frame.bytes[14], frame.bytes[13], frame.bytes[12]};
    cur_y     = {frame.bytes[11], frame.bytes[10], frame.bytes[9]};
    cur_z     = {frame.bytes[8], frame.bytes[7], frame.bytes[6]};
    cur_pitch = {frame.bytes[5], frame.bytes[4]};
    cur_yaw   = {frame.bytes[3], frame.bytes[2]};
    cur_roll  = {frame.bytes[1], frame.bytes[0]};
    diff = ({frame.flags, cur_x, cur_y, cur_z, cur_pitch, cur_yaw, cur_roll} !=
            {last_flags, last_x, last_y, last_z, last_pitch, last_yaw, last_roll});
  end

  // previous report
  always_ff @(posedge clk) begin
    if (rst) begin
      last_x     <= '1;
      last_y     <= '0;
      last_z     <= '0;
      last_pitch <= '0;
      last_yaw   <= '0;
      last_roll  <= '0;
      last_flags <= '0;
    end else if (frame.done) begin
      last_x     <= cur_x;
      last_y     <= cur_y;
      last_z     <= cur_z;
      last_pitch <= cur_pitch;
      last_yaw   <= cur_yaw;
      last_roll  <= cur_roll;
      last_flags <= frame.flags;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      rpt.valid <= 1'b0;
    end else if (frame.done) begin
      rpt.valid <= 1'b1;
    end else if (rpt.ready) begin
      rpt.valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (frame.done) begin
      rpt.pos_x        <= cur_x;
      rpt.pos_y        <= cur_y;
      rpt.pos_z        <= cur_z;
      rpt.pitch        <= cur_pitch;
      rpt.yaw          <= cur_yaw;
      rpt.roll         <= cur_roll;
      rpt.fringe       <= frame.flags[5];
      rpt.out_of_range <= frame.flags[4];
      rpt.buttons      <= frame.flags[3:0];
      rpt.changed      <= diff;
      rpt.resynced     <= frame.resync;
    end
  end

endmodule

// File: rtl/trd_checker.sv
`timescale 1ns / 1ps
module trd_checker (
  input logic        clk,
  input logic        rst,
  input logic        rx_valid,
  input logic        rx_ready,
  input logic        rpt_valid,
  input logic        rpt_ready,
  input logic [20:0] rpt_pos_x,
  input logic        rpt_changed
);

  a_reset_idle: assert property (@(posedge clk) rst |=> !rpt_valid)
    else $error("report valid after reset");

  a_report_from_byte: assert property (@(posedge clk) disable iff (rst)
    $rose(rpt_valid) |-> $past(rx_valid && rx_ready))
    else $error("report without a preceding byte");

  a_ready_only_on_stall: assert property (@(posedge clk) disable iff (rst)
    !rx_ready |-> (rpt_valid && !rpt_ready))
    else $error("rx stalled without a stalled report");

  a_stall_hold: assert property (@(posedge clk) disable iff (rst)
    (rpt_valid && !rpt_ready) |=>
      (rpt_valid && $stable(rpt_pos_x) && $stable(rpt_changed)))
    else $error("stalled report changed");

endmodule

bind tracker_report_deframer trd_checker u_trd_checker (
  .clk         (clk),
  .rst         (rst),
  .rx_valid    (rx.valid),
  .rx_ready    (rx.ready),
  .rpt_valid   (rpt.valid),
  .rpt_ready   (rpt.ready),
  .rpt_pos_x   (rpt.pos_x),
  .rpt_changed (rpt.changed)
);

// File: tb/trd_report_checker.sv
`timescale 1ns / 1ps
module trd_report_checker
  import trd_pkg::*;
(
  input  logic  clk,
  input  logic  rst,
  trd_byte_if   rx,
  trd_report_if rpt,
  output int    fail_count,
  output int    pending,
  output int    report_count,
  output int    resync_count,
  output int    unchanged_count
);

  typedef struct {
    logic signed [POS_W-1:0] pos_x;
    logic signed [POS_W-1:0] pos_y;
    logic signed [POS_W-1:0] pos_z;
    logic signed [ANG_W-1:0] pitch;
    logic signed [ANG_W-1:0] yaw;
    logic signed [ANG_W-1:0] roll;
    logic                    fringe;
    logic                    out_of_range;
    logic [3:0]              buttons;
    logic                    changed;
    logic                    resynced;
  } tracker_report_t;

  tracker_report_t   pending_reports[$];
  logic [3:0]        frame_idx;
  logic [FLAG_W-1:0] hdr_flags;
  dbyte_t            data_bytes[DATA_BYTES];
  logic              drop_seen;
  logic [POS_W-1:0]  prev_pos[3];
  logic [ANG_W-1:0]  prev_ang[3];
  logic [FLAG_W-1:0] prev_flags;
  int                fails = 0;
  int                reports = 0;
  int                resyncs = 0;
  int                unchanged = 0;

  function automatic void deframe_byte(logic [7:0] b);
    tracker_report_t  r;
    logic [POS_W-1:0] pos[3];
    logic [ANG_W-1:0] ang[3];
    logic             diff;
    int               i;
    if (frame_idx == IDX_START) begin
      if (!b[7]) begin
        drop_seen = 1'b1;
      end else begin
        hdr_flags = {b[6:5], b[3:0]};
        frame_idx = IDX_FIRST;
      end
      return;
    end
    data_bytes[frame_idx - IDX_FIRST] = b[6:0];
    if (frame_idx != IDX_LAST) begin
      frame_idx = frame_idx + 4'd1;
      return;
    end
    frame_idx = IDX_START;
    diff = (hdr_flags != prev_flags);
    for (i = 0; i < 3; i++) begin
      pos[i] = {data_bytes[3*i], data_bytes[3*i+1], data_bytes[3*i+2]};
      ang[i] = {data_bytes[9+2*i], data_bytes[10+2*i]};
      if (pos[i] != prev_pos[i] || ang[i] != prev_ang[i]) diff = 1'b1;
      prev_pos[i] = pos[i];
      prev_ang[i] = ang[i];
    end
    prev_flags = hdr_flags;
    r.pos_x = pos[0];
    r.pos_y = pos[1];
    r.pos_z = pos[2];
    r.pitch = ang[0];
    r.yaw = ang[1];
    r.roll = ang[2];
    r.fringe = hdr_flags[5];
    r.out_of_range = hdr_flags[4];
    r.buttons = hdr_flags[3:0];
    r.changed = diff;
    r.resynced = drop_seen;
    drop_seen = 1'b0;
    pending_reports.push_back(r);
  endfunction

  function automatic void check_field(string name, longint want, longint got);
    if (want != got) begin
      fails++;
      $display("%0t: report %0d %s mismatch: expected %0d, got %0d",
               $time, reports, name, want, got);
    end
  endfunction

  function automatic void check_report();
    tracker_report_t want;
    if (pending_reports.size() == 0) begin
      fails++;
      $display("%0t: report with no frame behind it: expected none, got x=%0d",
               $time, rpt.pos_x);
      return;
    end
    want = pending_reports.pop_front();
    check_field("pos_x", want.pos_x, rpt.pos_x);
    check_field("pos_y", want.pos_y, rpt.pos_y);
    check_field("pos_z", want.pos_z, rpt.pos_z);
    check_field("pitch", want.pitch, rpt.pitch);
    check_field("yaw", want.yaw, rpt.yaw);
    check_field("roll", want.roll, rpt.roll);
    check_field("fringe", want.fringe, rpt.fringe);
    check_field("out_of_range", want.out_of_range, rpt.out_of_range);
    check_field("buttons", want.buttons, rpt.buttons);
    check_field("changed", want.changed, rpt.changed);
    check_field("resynced", want.resynced, rpt.resynced);
    reports++;
    if (want.resynced) resyncs++;
    if (!want.changed) unchanged++;
  endfunction

  always @(posedge clk) begin
    if (rst) begin
      frame_idx = IDX_START;
      hdr_flags = '0;
      drop_seen = 1'b0;
      prev_pos[0] = '1;
      prev_pos[1] = '0;
      prev_pos[2] = '0;
      prev_ang[0] = '0;
      prev_ang[1] = '0;
      prev_ang[2] = '0;
      prev_flags = '0;
      pending_reports.delete();
    end else begin
      if (rx.valid && rx.ready) deframe_byte(rx.rx_byte);
      if (rpt.valid && rpt.ready) check_report();
    end
    fail_count <= fails;
    pending <= pending_reports.size();
    report_count <= reports;
    resync_count <= resyncs;
    unchanged_count <= unchanged;
  end

endmodule

// File: tb/tb_tracker_report_deframer.sv
`timescale 1ns / 1ps
module tb_tracker_report_deframer;
  import trd_pkg::*;

  localparam int ITEMS = 2000;
  localparam int PHASES = 4;
  localparam int HOLD_CYCLES = 300;
  localparam int IDLE_LIMIT = 2000;
  localparam int DRAIN_CYCLES = 10;
  localparam int RST_CYCLES = 7;

  logic clk = 1'b0;
  logic rst = 1'b1;

  trd_byte_if   rx ();
  trd_report_if rpt ();

  int fail_count;
  int pending;
  int report_count;
  int resync_count;
  int unchanged_count;
  int byte_count = 0;
  int rx_max_gap = 7;
  int rpt_max_stall = 7;
  bit hold_reports = 1'b0;
  int idle_cycles = 0;

  logic [POS_W-1:0] frame_pos[3];
  logic [ANG_W-1:0] frame_ang[3];
  logic [7:0]       frame_hdr;

  tracker_report_deframer DUT (
    .clk(clk),
    .rst(rst),
    .rx(rx),
    .rpt(rpt)
  );

  trd_report_checker report_check (
    .clk(clk),
    .rst(rst),
    .rx(rx),
    .rpt(rpt),
    .fail_count(fail_count),
    .pending(pending),
    .report_count(report_count),
    .resync_count(resync_count),
    .unchanged_count(unchanged_count)
  );

  always #10 clk = ~clk;

  always @(posedge clk) begin
    if (rst || (rx.valid && rx.ready) || (rpt.valid && rpt.ready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles == IDLE_LIMIT) begin
      $display("%0t: no request moved for %0d cycles", $time, IDLE_LIMIT);
      $display("tb_tracker_report_deframer: FAIL");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  // report receiver
  initial begin
    int stall;
    rpt.ready <= 1'b0;
    @(posedge clk);
    while (rst) @(posedge clk);
    forever begin
      if (hold_reports) begin
        stall = HOLD_CYCLES;
        hold_reports = 1'b0;
      end else begin
        stall = $urandom_range(0, rpt_max_stall);
      end
      if (stall > 0) begin
        rpt.ready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      rpt.ready <= 1'b1;
      @(posedge clk);
      while (!rpt.valid) @(posedge clk);
    end
  end

  task automatic send_byte(input logic [7:0] b);
    int gap;
    gap = $urandom_range(0, rx_max_gap);
    if (gap > 0) begin
      rx.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    rx.valid <= 1'b1;
    rx.rx_byte <= b;
    @(posedge clk);
    while (!rx.ready) @(posedge clk);
  endtask

  task automatic send_noise();
    send_byte({1'b0, 7'($urandom)});
  endtask

  task automatic send_frame(input logic [7:0] hdr, input int ndata);
    dbyte_t data[DATA_BYTES];
    int     i;
    for (i = 0; i < 3; i++) begin
      {data[3*i], data[3*i+1], data[3*i+2]} = frame_pos[i];
      {data[9+2*i], data[10+2*i]} = frame_ang[i];
    end
    send_byte(hdr);
    // bit 7 of data bytes is don't-care
    for (i = 0; i < ndata; i++) send_byte({1'($urandom), data[i]});
    byte_count += ndata + 1;
  endtask

  task automatic set_frame(input logic [POS_W-1:0] x, y, z,
                           input logic [ANG_W-1:0] p, w, r);
    frame_pos[0] = x;
    frame_pos[1] = y;
    frame_pos[2] = z;
    frame_ang[0] = p;
    frame_ang[1] = w;
    frame_ang[2] = r;
  endtask

  function automatic logic [POS_W-1:0] pick_pos();
    case ($urandom_range(0, 7))
      0: return {1'b0, {(POS_W-1){1'b1}}};
      1: return {1'b1, {(POS_W-1){1'b0}}};
      2: return '0;
      3: return '1;
      default: return POS_W'($urandom);
    endcase
  endfunction

  function automatic logic [ANG_W-1:0] pick_ang();
    case ($urandom_range(0, 7))
      0: return {1'b0, {(ANG_W-1){1'b1}}};
      1: return {1'b1, {(ANG_W-1){1'b0}}};
      2: return '0;
      3: return '1;
      default: return ANG_W'($urandom);
    endcase
  endfunction

  task automatic wait_reports();
    rx.valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
  endtask

  initial begin
    int phase;
    int target;
    int kind;
    int i;
    rx.valid <= 1'b0;
    rx.rx_byte <= '0;
    repeat (RST_CYCLES) @(posedge clk);
    rst <= 1'b0;

    // dropped bytes before the first header, first frame equal to reset state
    send_noise();
    send_byte(8'h7f);
    set_frame('1, '0, '0, '0, '0, '0);
    send_frame(8'h80, DATA_BYTES);
    set_frame({1'b0, {(POS_W-1){1'b1}}}, {1'b1, {(POS_W-1){1'b0}}}, '1,
              {1'b0, {(ANG_W-1){1'b1}}}, {1'b1, {(ANG_W-1){1'b0}}}, '1);
    send_frame(8'hff, DATA_BYTES);
    frame_hdr = 8'hff;
    wait_reports();

    for (phase = 0; phase < PHASES; phase++) begin
      case (phase)
        0: begin
          rx_max_gap = 7;
          rpt_max_stall = 7;
        end
        1: begin
          rx_max_gap = 0;
          rpt_max_stall = 0;
        end
        2: begin
          rx_max_gap = 0;
          rpt_max_stall = 7;
          hold_reports = 1'b1;
        end
        default: begin
          rx_max_gap = 7;
          rpt_max_stall = 0;
        end
      endcase
      target = byte_count + ITEMS / PHASES;
      while (byte_count < target) begin
        kind = $urandom_range(0, 15);
        if (kind == 0) begin
          repeat ($urandom_range(1, 3)) send_noise();
        end else if (kind == 1) begin
          // cut-short frame, then enough filler to land back on a boundary
          send_frame({1'b1, 7'($urandom)}, $urandom_range(0, DATA_BYTES - 1));
          for (i = 0; i <= DATA_BYTES; i++) send_noise();
        end else begin
          if (kind > 3) begin
            frame_hdr = {1'b1, 7'($urandom)};
            for (i = 0; i < 3; i++) begin
              frame_pos[i] = pick_pos();
              frame_ang[i] = pick_ang();
            end
          end else begin
            // same report again, header bit 4 flipped
            frame_hdr[4] = ~frame_hdr[4];
          end
          send_frame(frame_hdr, DATA_BYTES);
        end
      end
      wait_reports();
    end

    repeat (DRAIN_CYCLES) @(posedge clk);
    $display("sent %0d frame bytes plus noise, checked %0d reports", byte_count,
             report_count);
    $display("%0d reports came after dropped bytes, %0d matched the one before",
             resync_count, unchanged_count);
    if (fail_count == 0 && pending == 0) begin
      $display("tb_tracker_report_deframer: PASS");
    end else begin
      $display("tb_tracker_report_deframer: FAIL");
    end
    $finish;
  end

endmodule
